// ===== sv/rational_accumulator_unit_macros.svh =====
// Assertion macros for the rational accumulator unit.
// Included by the files that carry concurrent assertions; needs clk and rst in scope.
`ifndef RATIONAL_ACCUMULATOR_UNIT_MACROS_SVH
`define RATIONAL_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rau assertion failed");
`define RAU_ASSERT_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rau assertion failed");
`else
`define RAU_ASSERT_NEVER(label, cond)
`define RAU_ASSERT_IMPLIES(label, pre, post)
`endif
`endif

// ===== sv/rau_pkg.sv =====
// Shared constants and types of the rational accumulator unit.
// Used by rau_div and rational_accumulator_unit; depends on nothing.
package rau_pkg;
  localparam int WORD_BITS = 32;
  localparam int DIV_STEPS = WORD_BITS;
  localparam int CNT_BITS = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_INC  = 3'd2;
  localparam logic [2:0] OP_DEC  = 3'd3;
  localparam logic [2:0] OP_CMP  = 3'd4;

  typedef struct packed {
    logic                        start;
    logic signed [WORD_BITS-1:0] dividend;
    logic signed [WORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [WORD_BITS-1:0] quotient;
    logic signed [WORD_BITS-1:0] remainder;
  } div_rsp_t;
endpackage

// ===== sv/rau_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rau_pkg.
module rau_div (
  input  logic               clk,
  input  logic               rst,
  input  rau_pkg::div_req_t  req,
  output rau_pkg::div_rsp_t  rsp
);
  logic                            busy;
  logic [rau_pkg::CNT_BITS-1:0]    cnt;
  logic [rau_pkg::WORD_BITS-1:0]   dq;
  logic [rau_pkg::WORD_BITS-1:0]   dv;
  logic [rau_pkg::WORD_BITS-1:0]   rem;
  logic                            neg_q;
  logic                            neg_r;
  logic [rau_pkg::WORD_BITS:0]     rem_sh;
  logic                            fits;

  assign rem_sh = {rem, dq[rau_pkg::WORD_BITS-1]};
  assign fits   = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      cnt   <= rau_pkg::CNT_BITS'(rau_pkg::DIV_STEPS);
      dq    <= req.dividend[rau_pkg::WORD_BITS-1] ? (~req.dividend + 1'b1) : req.dividend;
      dv    <= req.divisor[rau_pkg::WORD_BITS-1] ? (~req.divisor + 1'b1) : req.divisor;
      rem   <= '0;
      neg_q <= req.dividend[rau_pkg::WORD_BITS-1] ^ req.divisor[rau_pkg::WORD_BITS-1];
      neg_r <= req.dividend[rau_pkg::WORD_BITS-1];
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= fits ? rau_pkg::WORD_BITS'(rem_sh - {1'b0, dv})
                    : rem_sh[rau_pkg::WORD_BITS-1:0];
        dq  <= {dq[rau_pkg::WORD_BITS-2:0], fits};
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.done      = busy && (cnt == '0);
  assign rsp.quotient  = neg_q ? (~dq + 1'b1) : dq;
  assign rsp.remainder = neg_r ? (~rem + 1'b1) : rem;
endmodule

// ===== sv/rational_accumulator_unit.sv =====
// Rational accumulator unit: top level with the sequencer, shared multiplier
// and accumulator. Depends on rau_pkg, rau_div and the assertion macro header.
//
// The block holds one signed fraction. Each input transaction on the s_ group
// carries an opcode (load, add, increment, decrement, compare) and an operand
// fraction; each one yields exactly one output transaction on the m_ group with
// the accumulator after the operation and the equal, less, nonzero and
// zero-denominator flags.
// An item is worked on by a small sequencer around one 32x32 signed multiplier
// and one shared bit-serial divider. Reduction runs Euclid's algorithm, one
// division per remainder step, then two more divisions by the GCD. An add first
// passes the multiplier states S_MUL0, S_MUL1 and S_MUL2, and a compare ends with
// S_CMP0 and S_CMP1. Rejected items and unused opcodes skip the divider and go to
// S_DONE. s_tready is high only while no item is in work.
// The result sits in an output register; a stalled receiver holds it, and the
// next item may be taken and computed meanwhile, but it waits at its end until
// the register is free. Synchronous reset sets the accumulator to 0/1 and
// clears m_tvalid; the sequencer returns to idle.
`include "rational_accumulator_unit_macros.svh"
module rational_accumulator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: opcode[2:0], operand_numerator[34:3],
  // operand_denominator[66:35], zero fill[71:67].
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: result_numerator[31:0], result_denominator[63:32],
  // is_equal[64], is_less[65], is_nonzero[66], zero_denominator[67], fill[71:68].
  output logic [71:0] m_tdata
);
  localparam int W = rau_pkg::WORD_BITS;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL0      = 4'd1;
  localparam logic [3:0] S_MUL1      = 4'd2;
  localparam logic [3:0] S_MUL2      = 4'd3;
  localparam logic [3:0] S_GCD_START = 4'd4;
  localparam logic [3:0] S_GCD_WAIT  = 4'd5;
  localparam logic [3:0] S_QN_START  = 4'd6;
  localparam logic [3:0] S_QN_WAIT   = 4'd7;
  localparam logic [3:0] S_QD_START  = 4'd8;
  localparam logic [3:0] S_QD_WAIT   = 4'd9;
  localparam logic [3:0] S_SIGN      = 4'd10;
  localparam logic [3:0] S_CMP0      = 4'd11;
  localparam logic [3:0] S_CMP1      = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [3:0]            state;
  logic [2:0]            op;
  logic signed [W-1:0]   opn, opd;
  logic signed [W-1:0]   acc_n, acc_d;
  logic signed [W-1:0]   wn, wd;     // fraction being reduced
  logic signed [W-1:0]   ex, ey;     // Euclid pair
  logic signed [W-1:0]   tmp;
  logic signed [2*W-1:0] p1;
  logic                  eq, less, zden;

  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [2*W-1:0] prod;
  logic [W-1:0]          sum_n;

  rau_pkg::div_req_t     dreq;
  rau_pkg::div_rsp_t     drsp;

  logic                  in_acc;
  logic [2:0]            in_op;
  logic signed [W-1:0]   in_n, in_d;

  assign in_acc = s_tvalid && s_tready;
  assign in_op  = s_tdata[2:0];
  assign in_n   = s_tdata[W+2:3];
  assign in_d   = s_tdata[2*W+2:W+3];
  assign s_tready = (state == S_IDLE);

  rau_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // The divider serves the Euclid steps and both divisions by the GCD.
  always_comb begin
    dreq.start    = (state == S_GCD_START) || (state == S_QN_START) ||
                    (state == S_QD_START);
    dreq.dividend = ex;
    dreq.divisor  = ey;
    if (state == S_QN_START) begin
      dreq.dividend = wn;
      dreq.divisor  = ex;
    end else if (state == S_QD_START) begin
      dreq.dividend = wd;
      dreq.divisor  = ex;
    end
  end

  // One shared multiplier; its operands follow the sequencer step.
  always_comb begin
    mul_a = acc_d;
    mul_b = opd;
    unique case (state)
      S_MUL1: begin
        mul_a = opd;
        mul_b = acc_n;
      end
      S_MUL2: begin
        mul_a = opn;
        mul_b = acc_d;
      end
      S_CMP0: begin
        mul_a = acc_n;
        mul_b = wd;
      end
      S_CMP1: begin
        mul_a = wn;
        mul_b = acc_d;
      end
      default: begin
        mul_a = acc_d;
        mul_b = opd;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign sum_n = tmp + prod[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      acc_n    <= '0;
      acc_d    <= W'(1);
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            op   <= in_op;
            opn  <= in_n;
            opd  <= in_d;
            eq   <= 1'b0;
            less <= 1'b0;
            zden <= 1'b0;
            if (in_op == rau_pkg::OP_LOAD || in_op == rau_pkg::OP_CMP) begin
              if (in_d == '0) begin
                zden  <= 1'b1;
                state <= S_DONE;
              end else begin
                wn    <= in_n;
                wd    <= in_d;
                ex    <= in_n;
                ey    <= in_d;
                state <= S_GCD_START;
              end
            end else if (in_op == rau_pkg::OP_ADD) begin
              state <= S_MUL0;
            end else if (in_op == rau_pkg::OP_INC || in_op == rau_pkg::OP_DEC) begin
              wn    <= (in_op == rau_pkg::OP_INC) ? acc_n + acc_d : acc_n - acc_d;
              ex    <= (in_op == rau_pkg::OP_INC) ? acc_n + acc_d : acc_n - acc_d;
              wd    <= acc_d;
              ey    <= acc_d;
              state <= S_GCD_START;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MUL0: begin
          wd <= prod[W-1:0];
          ey <= prod[W-1:0];
          if (prod[W-1:0] == '0) begin
            zden  <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          tmp   <= prod[W-1:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          wn    <= sum_n;
          ex    <= sum_n;
          state <= S_GCD_START;
        end
        S_GCD_START: begin
          state <= S_GCD_WAIT;
        end
        S_GCD_WAIT: begin
          if (drsp.done) begin
            ex    <= ey;
            ey    <= drsp.remainder;
            state <= (drsp.remainder == '0) ? S_QN_START : S_GCD_START;
          end
        end
        S_QN_START: begin
          state <= S_QN_WAIT;
        end
        S_QN_WAIT: begin
          if (drsp.done) begin
            wn    <= drsp.quotient;
            state <= S_QD_START;
          end
        end
        S_QD_START: begin
          state <= S_QD_WAIT;
        end
        S_QD_WAIT: begin
          if (drsp.done) begin
            wd    <= drsp.quotient;
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          // Move the sign into the numerator; the most negative word stays put.
          if (wd[W-1]) begin
            wn <= -wn;
            wd <= -wd;
          end
          if (op == rau_pkg::OP_CMP) begin
            state <= S_CMP0;
          end else begin
            acc_n <= wd[W-1] ? -wn : wn;
            acc_d <= wd[W-1] ? -wd : wd;
            state <= S_DONE;
          end
        end
        S_CMP0: begin
          p1    <= prod;
          state <= S_CMP1;
        end
        S_CMP1: begin
          less  <= p1 < prod;
          eq    <= (acc_n == wn) && (acc_d == wd);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'b0, zden, (acc_n != '0), less, eq, acc_d, acc_n};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The stored denominator can never become zero.
  `RAU_ASSERT_NEVER(a_acc_den_nonzero, acc_d == '0)
  // A rejected item reports no compare outcome.
  `RAU_ASSERT_NEVER(a_zden_no_cmp, (state == S_DONE) && zden && (eq || less))
  // Once an item is taken the block stops accepting until it is finished.
  `RAU_ASSERT_IMPLIES(a_busy_after_accept, in_acc, !s_tready)
  // The divider only reports completion while the sequencer waits for it.
  `RAU_ASSERT_NEVER(a_div_done_in_wait, drsp.done && !((state == S_GCD_WAIT) ||
                    (state == S_QN_WAIT) || (state == S_QD_WAIT)))
endmodule
